// ===== rtl/core/quadratic_extension_dot_product_top_assert.svh =====
// Assertion helpers for the dot product core.
`ifndef QUADRATIC_EXTENSION_DOT_PRODUCT_TOP_ASSERT_SVH
`define QUADRATIC_EXTENSION_DOT_PRODUCT_TOP_ASSERT_SVH

// same-cycle implication
`define QEDP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("qedp assertion failed");

// next-cycle implication
`define QEDP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("qedp assertion failed");

`endif

// ===== rtl/core/qedp_pkg.sv =====
`default_nettype none
package qedp_pkg;

  localparam int ELEM_W = 7;
  localparam int PROD_W = 14;
  localparam int WIDE_W = 16;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic valid;
    logic last;
  } qedp_tag_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } qedp_red_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/quadratic_extension_dot_product_top.sv =====
// Dot product over F_Q[x]/(x^2 - 3).
// Input channel (item_valid / item_stall): one element pair per transfer,
// a = a_re + a_im*x and b = b_re + b_im*x, plus last marking the final pair.
// Each pair adds a*b into two running sums, reduced exactly mod Q.
// Result channel (res_valid / res_stall): one transfer of c_re, c_im per
// item with last set; the sums then clear for the next dot product.
// Throughput: one pair per cycle, no gaps between rows, while no result stalls.
// Path of a last pair to its result: input register, product register,
// two Barrett reduction stages, then the accumulator feeding the output
// register. The product stage and the second reduction stage set the
// clock path.
// Stall: the result register holds until taken. Pairs without last keep
// flowing into the sums meanwhile; a last pair waits in the pipeline and
// stages behind it fill, after which item_stall rises.
// Reset (rst, synchronous): sums clear to zero, the pipeline empties.
`default_nettype none
module quadratic_extension_dot_product_top #(
  parameter int Q = 19
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  qedp_pkg::elem_t a_re,
  input  qedp_pkg::elem_t a_im,
  input  qedp_pkg::elem_t b_re,
  input  qedp_pkg::elem_t b_im,
  input  logic            last,
  output logic            res_valid,
  input  logic            res_stall,
  output qedp_pkg::elem_t c_re,
  output qedp_pkg::elem_t c_im
);
  import qedp_pkg::*;

  logic s0_valid, s1_valid, s2_valid, s3_valid;
  logic s0_last, s1_last, s2_last, s3_last;
  logic en0, en1, en2, en3;

  elem_t s0_a_re, s0_a_im, s0_b_re, s0_b_im;
  prod_t p_rr, p_ii, p_ri, p_ir;
  wide_t s1_rr, s1_ii3, s1_ri, s1_ir;
  elem_t r_rr, r_ii, r_ri, r_ir;

  qedp_red_ctl_t red_ctl;
  qedp_tag_t     tag3;

  assign en0 = !s0_valid || en1;
  assign en1 = !s1_valid || en2;
  assign en2 = !s2_valid || en3;
  assign item_stall = !en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en0) s0_valid <= item_valid;
      if (en1) s1_valid <= s0_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_a_re <= a_re;
      s0_a_im <= a_im;
      s0_b_re <= b_re;
      s0_b_im <= b_im;
      s0_last <= last;
    end
  end

  assign p_rr = {{ELEM_W{1'b0}}, s0_a_re} * {{ELEM_W{1'b0}}, s0_b_re};
  assign p_ii = {{ELEM_W{1'b0}}, s0_a_im} * {{ELEM_W{1'b0}}, s0_b_im};
  assign p_ri = {{ELEM_W{1'b0}}, s0_a_re} * {{ELEM_W{1'b0}}, s0_b_im};
  assign p_ir = {{ELEM_W{1'b0}}, s0_a_im} * {{ELEM_W{1'b0}}, s0_b_re};

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_rr   <= {2'b00, p_rr};
      s1_ii3  <= {2'b00, p_ii} + {1'b0, p_ii, 1'b0};
      s1_ri   <= {2'b00, p_ri};
      s1_ir   <= {2'b00, p_ir};
      s1_last <= s0_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) s2_last <= s1_last;
    if (en3) s3_last <= s2_last;
  end

  assign red_ctl.load_a = en2;
  assign red_ctl.load_b = en3;

  qedp_reduce #(.Q(Q)) u_red_rr (.clk(clk), .ctl(red_ctl), .v(s1_rr),  .r(r_rr));
  qedp_reduce #(.Q(Q)) u_red_ii (.clk(clk), .ctl(red_ctl), .v(s1_ii3), .r(r_ii));
  qedp_reduce #(.Q(Q)) u_red_ri (.clk(clk), .ctl(red_ctl), .v(s1_ri),  .r(r_ri));
  qedp_reduce #(.Q(Q)) u_red_ir (.clk(clk), .ctl(red_ctl), .v(s1_ir),  .r(r_ir));

  assign tag3.valid = s3_valid;
  assign tag3.last  = s3_last;

  qedp_accum #(.Q(Q)) u_accum (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag3),
    .r_rr      (r_rr),
    .r_ii      (r_ii),
    .r_ri      (r_ri),
    .r_ir      (r_ir),
    .load      (en3),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .c_re      (c_re),
    .c_im      (c_im)
  );

endmodule
`default_nettype wire

// ===== rtl/core/qedp_reduce.sv =====
`default_nettype none
module qedp_reduce #(
  parameter int Q = 19
) (
  input  logic                    clk,
  input  qedp_pkg::qedp_red_ctl_t ctl,
  input  qedp_pkg::wide_t         v,
  output qedp_pkg::elem_t         r
);
  import qedp_pkg::*;

  // Barrett: q_est = (v * floor(2^W / Q)) >> W, off by at most one
  localparam logic [WIDE_W-1:0] RECIP = WIDE_W'((1 << WIDE_W) / Q);
  localparam logic [ELEM_W-1:0] QV    = ELEM_W'(Q);
  localparam int                BW    = PROD_W + ELEM_W;

  logic [2*WIDE_W-1:0] est;
  wide_t               v_a;
  prod_t               q_a;
  logic [BW-1:0]       back;
  logic [BW-1:0]       diff;
  logic [ELEM_W:0]     rem;
  logic [ELEM_W:0]     rem_sub;

  assign est = {{WIDE_W{1'b0}}, v} * {{WIDE_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      v_a <= v;
      q_a <= est[WIDE_W +: PROD_W];
    end
  end

  assign back    = {{ELEM_W{1'b0}}, q_a} * {{PROD_W{1'b0}}, QV};
  assign diff    = {{(BW-WIDE_W){1'b0}}, v_a} - back;
  assign rem     = diff[ELEM_W:0];
  assign rem_sub = rem - {1'b0, QV};

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      r <= (rem >= {1'b0, QV}) ? rem_sub[ELEM_W-1:0] : rem[ELEM_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/qedp_accum.sv =====
`default_nettype none
`include "quadratic_extension_dot_product_top_assert.svh"
module qedp_accum #(
  parameter int Q = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  qedp_pkg::qedp_tag_t tag,
  input  qedp_pkg::elem_t     r_rr,
  input  qedp_pkg::elem_t     r_ii,
  input  qedp_pkg::elem_t     r_ri,
  input  qedp_pkg::elem_t     r_ir,
  output logic                load,
  output logic                res_valid,
  input  logic                res_stall,
  output qedp_pkg::elem_t     c_re,
  output qedp_pkg::elem_t     c_im
);
  import qedp_pkg::*;

  localparam int                T_W   = ELEM_W + 2;
  localparam logic [T_W-1:0]    Q_ONE = T_W'(Q);
  localparam logic [T_W-1:0]    Q_TWO = T_W'(2 * Q);

  elem_t          sum_re;
  elem_t          sum_im;
  logic [T_W-1:0] t_re;
  logic [T_W-1:0] t_im;
  elem_t          n_re;
  elem_t          n_im;
  logic           out_free;
  logic           take;
  logic           held_last;

  // t < 3Q
  function automatic elem_t fold(input logic [T_W-1:0] t);
    logic [T_W-1:0] u;
    priority if (t >= Q_TWO) u = t - Q_TWO;
    else if (t >= Q_ONE)     u = t - Q_ONE;
    else                     u = t;
    return u[ELEM_W-1:0];
  endfunction

  assign t_re = {2'b00, sum_re} + {2'b00, r_rr} + {2'b00, r_ii};
  assign t_im = {2'b00, sum_im} + {2'b00, r_ri} + {2'b00, r_ir};
  assign n_re = fold(t_re);
  assign n_im = fold(t_im);

  // non-last items only touch the sums, so they never wait on the output
  assign out_free  = !res_valid || !res_stall;
  assign load      = !tag.valid || !tag.last || out_free;
  assign take      = tag.valid && load;
  assign held_last = tag.valid && tag.last && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_re    <= '0;
      sum_im    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        if (tag.last) begin
          sum_re <= '0;
          sum_im <= '0;
        end else begin
          sum_re <= n_re;
          sum_im <= n_im;
        end
      end
      if (out_free) begin
        res_valid <= tag.valid && tag.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && tag.valid && tag.last) begin
      c_re <= n_re;
      c_im <= n_im;
    end
  end

  `QEDP_ASSERT_IMP(a_sum_range, clk, rst, 1'b1, sum_re < Q && sum_im < Q)
  `QEDP_ASSERT_IMP(a_res_range, clk, rst, res_valid, c_re < Q && c_im < Q)
  `QEDP_ASSERT_NEXT(a_clear_on_last, clk, rst, take && tag.last, sum_re == '0 && sum_im == '0)
  `QEDP_ASSERT_NEXT(a_held_last, clk, rst, held_last, $stable(sum_re) && $stable(sum_im))

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qedp_pkg::*;

  localparam int Q = 19;
  localparam int STUCK_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    elem_t re;
    elem_t im;
  } ext_elem_t;

  logic  clk;
  logic  rst;
  logic  item_valid;
  logic  item_stall;
  elem_t a_re, a_im, b_re, b_im;
  logic  last;
  logic  res_valid;
  logic  res_stall;
  elem_t c_re, c_im;

  ext_elem_t dot_q[$];
  elem_t     run_re, run_im;
  int        errors = 0;
  bit        send_idle = 0;
  bit        recv_idle = 0;
  int        stall_left = 0;
  int        stuck = 0;

  quadratic_extension_dot_product_top #(.Q(Q)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .last(last),
    .res_valid(res_valid), .res_stall(res_stall),
    .c_re(c_re), .c_im(c_im)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  // Running extension-field dot product; pushes the sums on a last pair.
  function automatic void accumulate_pair(elem_t ar, elem_t ai, elem_t br, elem_t bi,
                                          logic lst);
    int unsigned p_re, p_im;
    ext_elem_t   nxt;
    p_re = (int'(ar) * int'(br)) % Q + (3 * int'(ai) * int'(bi)) % Q;
    p_im = (int'(ar) * int'(bi)) % Q + (int'(ai) * int'(br)) % Q;
    nxt.re = elem_t'((int'(run_re) + p_re) % Q);
    nxt.im = elem_t'((int'(run_im) + p_im) % Q);
    if (lst) begin
      dot_q.push_back(nxt);
      run_re = '0;
      run_im = '0;
    end else begin
      run_re = nxt.re;
      run_im = nxt.im;
    end
  endfunction

  // input transfer monitor / predictor
  always @(posedge clk) begin
    if (rst) begin
      run_re = '0;
      run_im = '0;
    end else if (item_valid && !item_stall) begin
      accumulate_pair(a_re, a_im, b_re, b_im, last);
    end
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    ext_elem_t want;
    if (!rst && res_valid && !res_stall) begin
      if (dot_q.size() == 0) begin
        report_error($sformatf("unexpected result c_re=%0d c_im=%0d", c_re, c_im));
      end else begin
        want = dot_q.pop_front();
        if (c_re !== want.re)
          report_error($sformatf("c_re got %0d, expected %0d", c_re, want.re));
        if (c_im !== want.im)
          report_error($sformatf("c_im got %0d, expected %0d", c_im, want.im));
      end
      stall_left = recv_idle ? $urandom_range(0, 6) : 0;
    end
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  initial begin
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (res_valid && !res_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_pair(elem_t ar, elem_t ai, elem_t br, elem_t bi, logic lst);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    a_re <= ar;
    a_im <= ai;
    b_re <= br;
    b_im <= bi;
    last <= lst;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic wait_results_in();
    item_valid <= 1'b0;
    @(posedge clk);
    while (dot_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic elem_t pick_elem();
    if ($urandom_range(0, 9) < 7)
      return elem_t'($urandom_range(0, Q - 1));
    return elem_t'($urandom_range(0, 127));
  endfunction

  task automatic test_single_pairs();
    elem_t qm1, qv;
    qm1 = elem_t'(Q - 1);
    qv  = elem_t'(Q);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_pair(7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
    send_pair(7'd127, 7'd127, 7'd127, 7'd127, 1'b1);
    send_pair(7'd126, 7'd126, 7'd126, 7'd126, 1'b1);
    send_pair(qm1, qm1, qm1, qm1, 1'b1);
    send_pair(qv, qv, qv, qv, 1'b1);
    send_pair(7'd1, 7'd0, 7'd1, 7'd0, 1'b1);
    send_pair(7'd0, 7'd1, 7'd0, 7'd1, 1'b1);
    send_pair(7'd127, 7'd0, 7'd0, 7'd127, 1'b1);
    send_pair(7'd0, 7'd127, 7'd127, 7'd0, 1'b1);
    wait_results_in();
  endtask

  task automatic test_rows();
    elem_t qm1;
    qm1 = elem_t'(Q - 1);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (3) send_pair(7'd127, 7'd127, 7'd127, 7'd127, 1'b0);
    send_pair(7'd126, 7'd1, 7'd2, 7'd3, 1'b1);
    repeat (2) send_pair(qm1, qm1, qm1, qm1, 1'b0);
    send_pair(7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
    send_pair(7'd1, 7'd2, 7'd3, 7'd4, 1'b0);
    send_pair(7'd5, 7'd6, 7'd7, 7'd8, 1'b0);
    send_pair(7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
    // sender holds off until the pipeline is empty
    wait_results_in();
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    repeat (80) send_pair(pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                          $urandom_range(0, 9) < 7);
    wait_results_in();
  endtask

  task automatic test_random_rows();
    int sent, len;
    sent = 0;
    while (sent < 800) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      for (int i = 0; i < len; i++)
        send_pair(pick_elem(), pick_elem(), pick_elem(), pick_elem(), i == len - 1);
      sent += len;
      if ($urandom_range(0, 19) == 0)
        wait_results_in();
    end
    wait_results_in();
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    a_re <= '0;
    a_im <= '0;
    b_re <= '0;
    b_im <= '0;
    last <= 1'b0;
    res_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_single_pairs();
    test_rows();
    test_backpressure();
    test_random_rows();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
